// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/spiwr_pkg.sv =====
package spiwr_pkg;

    // default frame length in bits
    localparam int WORD_BITS_DEF = 32;

    // fixed port widths
    localparam int IN_WORD_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 8;

    // sequencer phases, one-hot
    typedef enum logic [6:0] {
        PH_STOP     = 7'b0000001,
        PH_CS_DOWN  = 7'b0000010,
        PH_DATA     = 7'b0000100,
        PH_CLK_UP   = 7'b0001000,
        PH_HOLD     = 7'b0010000,
        PH_CLK_DOWN = 7'b0100000,
        PH_CS_UP    = 7'b1000000
    } phase_t;

    // input mode codes
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    // result word, chip_select_n in bit 0
    typedef struct packed {
        logic pending;
        logic busy_res;
        logic serial_out;
        logic serial_clock;
        logic chip_select_n;
    } res_t;

    // handshake between output stage and sequencer
    typedef struct packed {
        logic step;
    } ctrl_t;

endpackage

// ===== hdl/spiwr_seq.sv =====
`include "assert_macros.svh"

module spiwr_seq #(
    parameter int WORD_BITS = spiwr_pkg::WORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spiwr_pkg::ctrl_t                 ctrl,
    input  logic                             mode,
    input  logic [spiwr_pkg::IN_WORD_W-1:0]  word_in,
    output spiwr_pkg::res_t                  res
);
    import spiwr_pkg::*;

    localparam int BIT_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int COPY_W = (WORD_BITS < IN_WORD_W) ? WORD_BITS : IN_WORD_W;

    phase_t                 phase_reg, phase_next;
    logic [WORD_BITS-1:0]   shift_word_reg, shift_word_next;
    logic [BIT_W-1:0]       bit_pos_reg, bit_pos_next;
    logic [WORD_BITS-1:0]   held_word_reg, held_word_next;
    logic                   held_valid_reg, held_valid_next;
    logic                   cs_n_reg, cs_n_next;
    logic                   sclk_reg, sclk_next;
    logic                   sdo_reg, sdo_next;
    logic [WORD_BITS-1:0]   load_word;
    logic                   busy;

    // frame word from the input, upper bits zero when the frame is wider
    always_comb
    begin
        load_word = '0;
        load_word[COPY_W-1:0] = word_in[COPY_W-1:0];
    end

    // sequencer is running in any phase but stopped
    always_comb
    begin
        case (phase_reg)
            PH_CS_DOWN, PH_DATA, PH_CLK_UP, PH_HOLD, PH_CLK_DOWN, PH_CS_UP: busy = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    // next state for one word
    always_comb
    begin
        phase_next      = phase_reg;
        shift_word_next = shift_word_reg;
        bit_pos_next    = bit_pos_reg;
        held_word_next  = held_word_reg;
        held_valid_next = held_valid_reg;
        cs_n_next       = cs_n_reg;
        sclk_next       = sclk_reg;
        sdo_next        = sdo_reg;
        if (mode == MODE_REQUEST)
        begin
            if (busy)
            begin
                held_word_next  = load_word;
                held_valid_next = 1'b1;
            end
            else
            begin
                shift_word_next = load_word;
                phase_next      = PH_CS_DOWN;
            end
        end
        else
        begin
            case (phase_reg)
                PH_CS_DOWN:
                begin
                    cs_n_next    = 1'b0;
                    bit_pos_next = BIT_W'(WORD_BITS - 1);
                    phase_next   = PH_DATA;
                end
                PH_DATA:
                begin
                    sdo_next   = shift_word_reg[bit_pos_reg];
                    phase_next = PH_CLK_UP;
                end
                PH_CLK_UP:
                begin
                    sclk_next  = 1'b1;
                    phase_next = PH_HOLD;
                end
                PH_HOLD:
                begin
                    phase_next = PH_CLK_DOWN;
                end
                PH_CLK_DOWN:
                begin
                    sclk_next = 1'b0;
                    if (bit_pos_reg == '0)
                    begin
                        phase_next = PH_CS_UP;
                    end
                    else
                    begin
                        bit_pos_next = bit_pos_reg - 1'b1;
                        phase_next   = PH_DATA;
                    end
                end
                PH_CS_UP:
                begin
                    cs_n_next = 1'b1;
                    if (held_valid_reg)
                    begin
                        shift_word_next = held_word_reg;
                        held_valid_next = 1'b0;
                        phase_next      = PH_CS_DOWN;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
                default:
                begin
                    phase_next = PH_STOP;
                end
            endcase
        end
    end

    // result reflects the state after this word
    always_comb
    begin
        res.chip_select_n = cs_n_next;
        res.serial_clock  = sclk_next;
        res.serial_out    = sdo_next;
        res.busy_res      = (phase_next != PH_STOP);
        res.pending       = held_valid_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_STOP;
            shift_word_reg <= '0;
            bit_pos_reg    <= '0;
            held_valid_reg <= 1'b0;
            cs_n_reg       <= 1'b1;
            sclk_reg       <= 1'b0;
            sdo_reg        <= 1'b0;
        end
        else if (ctrl.step)
        begin
            phase_reg      <= phase_next;
            shift_word_reg <= shift_word_next;
            bit_pos_reg    <= bit_pos_next;
            held_valid_reg <= held_valid_next;
            cs_n_reg       <= cs_n_next;
            sclk_reg       <= sclk_next;
            sdo_reg        <= sdo_next;
        end
    end

    // holding slot, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            held_word_reg <= held_word_next;
        end
    end

    `ASSERT_ALWAYS(a_pending_only_busy, clk, rst_n, !held_valid_reg || (phase_reg != PH_STOP), "holding slot full while sequencer stopped")
    `ASSERT_ALWAYS(a_clk_high_phase, clk, rst_n, !sclk_reg || (phase_reg == PH_HOLD) || (phase_reg == PH_CLK_DOWN), "serial clock high outside hold or clock-down phase")
    `ASSERT_ALWAYS(a_cs_high_stopped, clk, rst_n, (phase_reg != PH_STOP) || cs_n_reg, "chip select low while stopped")

endmodule

// ===== hdl/spiwr_obuf.sv =====
`include "assert_macros.svh"

module spiwr_obuf (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    output spiwr_pkg::ctrl_t                  ctrl,
    input  spiwr_pkg::res_t                   res,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [spiwr_pkg::OUT_DATA_W-1:0]  out_data
);
    import spiwr_pkg::*;

    logic out_valid_reg, out_valid_next;
    res_t res_reg;

    // take a new word whenever the result slot is free or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign ctrl.step = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_DATA_W'(res_reg);

    `ASSERT_NEXT(a_step_gives_result, clk, rst_n, ctrl.step, out_valid_reg, "accepted word left no result")

endmodule

// ===== hdl/three_wire_spi_write_serializer_top.sv =====
// channel  | dir | fields
// s_axis   | in  | tuser: mode; tdata: word_in[31:0]
// m_axis   | out | tdata: chip_select_n, serial_clock, serial_out, busy_res, pending
//
// one word in per cycle while the result register is free or drained, its result registered and shown the next cycle
// every input word (tick or request) gives exactly one result word
// s_axis_tready stays high while the result register is empty or drained
// rst_n is asynchronous: sequencer pins reset to select high, clock low, data low
// a stalled result holds; the sequencer only moves on accepted words

module three_wire_spi_write_serializer_top #(
    parameter int WORD_BITS = spiwr_pkg::WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [spiwr_pkg::IN_WORD_W-1:0]   s_axis_tdata,   // word_in
    input  logic [spiwr_pkg::IN_USER_W-1:0]   s_axis_tuser,   // mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // chip_select_n, serial_clock, serial_out, busy_res, pending, zero pad
    output logic [spiwr_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import spiwr_pkg::*;

    ctrl_t ctrl;
    res_t  res;

    // frame sequencer and holding slot
    spiwr_seq #(
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .mode    (s_axis_tuser[0]),
        .word_in (s_axis_tdata),
        .res     (res)
    );

    // result register and handshake
    spiwr_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .ctrl      (ctrl),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== bench/tb_three_wire_spi_write_serializer_top.sv =====
module tb_three_wire_spi_write_serializer_top;

    import spiwr_pkg::*;

    localparam int FRAME_BITS = WORD_BITS_DEF;
    localparam logic [63:0] FRAME_MASK =
        (FRAME_BITS >= 64) ? '1 : ((64'd1 << FRAME_BITS) - 64'd1);
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_WORDS = 1000;

    // one pending input word for the driver
    typedef struct {
        logic        mode;
        logic [31:0] word_in;
        logic        wait_idle;
    } spi_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_WORD_W-1:0]  s_axis_tdata = '0;    // word_in
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;    // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // chip_select_n, serial_clock, serial_out, busy_res, pending, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    spi_word_t spi_word_q[$];
    res_t      pin_expect_q[$];
    int        pin_errs = 0;
    int        idle_cycles = 0;

    // shadow copy of the sequencer
    phase_t      seq_phase = PH_STOP;
    logic [63:0] frame_word = '0;
    logic [5:0]  bit_idx = '0;
    logic [63:0] slot_word = '0;
    logic        slot_full = 1'b0;
    logic        pin_cs_n = 1'b1;
    logic        pin_sclk = 1'b0;
    logic        pin_sdo = 1'b0;

    string field_name[5] = '{"chip_select_n", "serial_clock", "serial_out",
                             "busy_res", "pending"};

    three_wire_spi_write_serializer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // advance the shadow sequencer by one word and return the pin levels
    function automatic res_t spi_pins_after(input logic mode, input logic [31:0] word_in);
        logic [63:0] word;
        res_t        pins;
        word = {32'd0, word_in} & FRAME_MASK;
        if (mode == MODE_REQUEST) begin
            if (seq_phase != PH_STOP) begin
                slot_word = word;
                slot_full = 1'b1;
            end
            else begin
                frame_word = word;
                seq_phase = PH_CS_DOWN;
            end
        end
        else begin
            case (seq_phase)
                PH_CS_DOWN:
                begin
                    pin_cs_n = 1'b0;
                    bit_idx = 6'(FRAME_BITS - 1);
                    seq_phase = PH_DATA;
                end
                PH_DATA:
                begin
                    pin_sdo = frame_word[bit_idx];
                    seq_phase = PH_CLK_UP;
                end
                PH_CLK_UP:
                begin
                    pin_sclk = 1'b1;
                    seq_phase = PH_HOLD;
                end
                PH_HOLD:
                begin
                    seq_phase = PH_CLK_DOWN;
                end
                PH_CLK_DOWN:
                begin
                    pin_sclk = 1'b0;
                    if (bit_idx == 6'd0)
                    begin
                        seq_phase = PH_CS_UP;
                    end
                    else
                    begin
                        bit_idx = bit_idx - 6'd1;
                        seq_phase = PH_DATA;
                    end
                end
                PH_CS_UP:
                begin
                    // reload from the holding slot or stop
                    pin_cs_n = 1'b1;
                    if (slot_full)
                    begin
                        frame_word = slot_word;
                        slot_full = 1'b0;
                        seq_phase = PH_CS_DOWN;
                    end
                    else
                    begin
                        seq_phase = PH_STOP;
                    end
                end
                default:
                begin
                    seq_phase = PH_STOP;
                end
            endcase
        end
        pins.chip_select_n = pin_cs_n;
        pins.serial_clock  = pin_sclk;
        pins.serial_out    = pin_sdo;
        pins.busy_res      = (seq_phase != PH_STOP);
        pins.pending       = slot_full;
        return pins;
    endfunction

    function automatic void queue_word(input logic mode, input logic [31:0] word_in,
                                       input logic wait_idle);
        spi_word_t w;
        w.mode = mode;
        w.word_in = word_in;
        w.wait_idle = wait_idle;
        spi_word_q.push_back(w);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // driver: bursts of words with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        spi_word_t w;
        int        burst_left;
        int        gap_left;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pin_expect_q.push_back(spi_pins_after(s_axis_tuser[0], s_axis_tdata));
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (spi_word_q.size() != 0 &&
                         !(spi_word_q[0].wait_idle && pin_expect_q.size() != 0))
                begin
                    w = spi_word_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= w.word_in;
                    s_axis_tuser  <= w.mode;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(5, 15);
                            default: gap_left = $urandom_range(1, 3);
                        endcase
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result word against the oldest expected pin state
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        int   rdy_style;
        int   rdy_left;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rdy_style = 0;
            rdy_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = res_t'(m_axis_tdata[4:0]);
                if (pin_expect_q.size() == 0)
                begin
                    if (pin_errs < 10)
                        $display("unexpected result word %b", got);
                    pin_errs++;
                end
                else
                begin
                    want = pin_expect_q.pop_front();
                    for (int i = 0; i < 5; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            if (pin_errs < 10)
                                $display("%s mismatch: expected %b, got %b",
                                         field_name[i], want[i], got[i]);
                            pin_errs++;
                        end
                    end
                end
            end
            // stall pattern: free running, coin flip, or mostly stalled
            if (rdy_left <= 0)
            begin
                rdy_style = $urandom_range(0, 2);
                rdy_left = $urandom_range(20, 200);
            end
            rdy_left--;
            case (rdy_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int n;
        int span;
        // tick while stopped, then a frame of ones with two writes to the slot
        queue_word(MODE_TICK, 32'h1234_5678, 1'b0);
        queue_word(MODE_REQUEST, 32'hFFFF_FFFF, 1'b0);
        queue_word(MODE_REQUEST, 32'h0000_0000, 1'b0);
        queue_word(MODE_REQUEST, 32'h8000_0001, 1'b0);
        // full frame, ends in a reload from the slot
        repeat (130) queue_word(MODE_TICK, 32'h0, 1'b0);
        // reach the final chip-select phase and request there
        repeat (129) queue_word(MODE_TICK, 32'hFFFF_FFFF, 1'b0);
        queue_word(MODE_REQUEST, 32'h0000_0000, 1'b0);
        repeat (131) queue_word(MODE_TICK, 32'h0, 1'b0);
        // ticks while stopped
        queue_word(MODE_TICK, 32'hFFFF_FFFF, 1'b0);
        queue_word(MODE_TICK, 32'h0, 1'b0);

        // random frames with sprinkled requests, plus some noise
        n = 0;
        while (n < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                span = $urandom_range(1, 6);
                repeat (span) queue_word(MODE_TICK, $urandom, 1'b0);
            end
            else
            begin
                queue_word(MODE_REQUEST, pick_word(), (n == 0) || (n > 700 && n < 720));
                span = $urandom_range(0, 300);
                for (int i = 0; i < span; i++)
                begin
                    if ($urandom_range(0, 49) == 0)
                        queue_word(MODE_REQUEST, pick_word(), 1'b0);
                    else
                        queue_word(MODE_TICK, $urandom, 1'b0);
                end
                n = n + span + 1;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (spi_word_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (pin_expect_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (pin_errs == 0 && pin_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
